@@ hdl/mlbs_pkg.sv @@
// Shared types and constants for the multi-LED blink scheduler.
`default_nettype none
package mlbs_pkg;

	localparam int NUM_LEDS_DEF   = 4;
	localparam int TIME_WIDTH_DEF = 16;
	localparam int UNIT_W         = 4;
	localparam int TICK_W         = 16;
	localparam int OUT_W          = 4;

	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_SET  = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [UNIT_W-1:0] led_unit;
		logic [TICK_W-1:0] on_ticks;
		logic [TICK_W-1:0] off_ticks;
	} req_t;

	typedef struct packed {
		logic [OUT_W-1:0] pin_levels;
		logic [OUT_W-1:0] running_mask;
	} res_t;

	typedef struct packed {
		logic tick;
		logic set;
	} led_cmd_t;

	typedef struct packed {
		logic running;
		logic lit;
	} led_stat_t;

endpackage
`default_nettype wire

@@ hdl/mlbs_if.sv @@
// Request and result channel interfaces.
`default_nettype none
interface mlbs_req_if;
	import mlbs_pkg::*;
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [UNIT_W-1:0] led_unit;
	logic [TICK_W-1:0] on_ticks;
	logic [TICK_W-1:0] off_ticks;

	modport source (output valid, req_type, led_unit, on_ticks, off_ticks, input ready);
	modport sink (input valid, req_type, led_unit, on_ticks, off_ticks, output ready);
endinterface

interface mlbs_res_if;
	import mlbs_pkg::*;
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] pin_levels;
	logic [OUT_W-1:0] running_mask;

	modport source (output valid, pin_levels, running_mask, input ready);
	modport sink (input valid, pin_levels, running_mask, output ready);
endinterface
`default_nettype wire

@@ hdl/multi_led_blink_scheduler_core.sv @@
// Top level of the multi-LED blink scheduler.
//
//   channel  dir  fields                                     handshake
//   req      in   req_type, led_unit, on_ticks, off_ticks    valid/ready
//   rsp      out  pin_levels, running_mask                   valid/ready
//   cfg      in   cfg_wdata (active_high)                    cfg_we, no wait
//
// One item per cycle sustained while rsp is ready.
// The input register holds the item, the per-LED update and result form in one
// step into the result register. A stall on rsp holds the result register and a
// full input register; req stays ready while the input register is empty or can
// drain into the result register.
// Reset clears all LEDs to stopped and off, active_high to 1.
`default_nettype none
module multi_led_blink_scheduler_core #(
	parameter int NUM_LEDS   = mlbs_pkg::NUM_LEDS_DEF,
	parameter int TIME_WIDTH = mlbs_pkg::TIME_WIDTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cfg_we,
	input  wire logic     cfg_wdata,
	mlbs_req_if.sink      req,
	mlbs_res_if.source    rsp
);
	import mlbs_pkg::*;

	localparam logic [OUT_W-1:0] OUT_MASK =
		(NUM_LEDS >= OUT_W) ? {OUT_W{1'b1}} : OUT_W'((1 << NUM_LEDS) - 1);

	logic                  active_high_q;
	logic                  valid_s1;
	req_t                  req_s1;
	logic                  valid_s2;
	res_t                  res_s2;
	logic                  adv;
	logic                  out_free;
	logic [TIME_WIDTH-1:0] on_time;
	logic [TIME_WIDTH-1:0] off_time;
	led_cmd_t              cmd [NUM_LEDS];
	led_stat_t             cur [NUM_LEDS];
	led_stat_t             nxt [NUM_LEDS];
	logic [NUM_LEDS-1:0]   run_vec;
	logic [NUM_LEDS-1:0]   lit_vec;
	res_t                  res_d;

	assign out_free  = !valid_s2 || rsp.ready;
	assign adv       = valid_s1 && out_free;
	assign req.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_high_q <= 1'b1;
		end else if (cfg_we) begin
			active_high_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1.req_type  <= req.req_type;
			req_s1.led_unit  <= req.led_unit;
			req_s1.on_ticks  <= req.on_ticks;
			req_s1.off_ticks <= req.off_ticks;
		end
		if (adv) begin
			res_s2 <= res_d;
		end
	end

	assign on_time  = TIME_WIDTH'(req_s1.on_ticks);
	assign off_time = TIME_WIDTH'(req_s1.off_ticks);

	for (genvar k = 0; k < NUM_LEDS; k++) begin : g_led
		assign cmd[k].tick = adv && (req_s1.req_type == REQ_TICK);
		assign cmd[k].set  = adv && (req_s1.req_type == REQ_SET)
			&& (req_s1.led_unit == UNIT_W'(k));
		assign run_vec[k]  = cur[k].running;
		assign lit_vec[k]  = cur[k].lit;

		mlbs_led #(
			.TIME_WIDTH(TIME_WIDTH)
		) u_led (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd[k]),
			.on_time (on_time),
			.off_time(off_time),
			.cur     (cur[k]),
			.nxt     (nxt[k])
		);
	end

	for (genvar b = 0; b < OUT_W; b++) begin : g_out
		if (b < NUM_LEDS) begin : g_used
			assign res_d.pin_levels[b]   = active_high_q ? nxt[b].lit : !nxt[b].lit;
			assign res_d.running_mask[b] = nxt[b].running;
		end else begin : g_unused
			assign res_d.pin_levels[b]   = 1'b0;
			assign res_d.running_mask[b] = 1'b0;
		end
	end

	assign rsp.valid        = valid_s2;
	assign rsp.pin_levels   = res_s2.pin_levels;
	assign rsp.running_mask = res_s2.running_mask;

	a_mask_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((res_s2.running_mask & ~OUT_MASK) == '0)
		&& ((res_s2.pin_levels & ~OUT_MASK) == '0))
		else $error("result bits set beyond LED count");

	a_stopped_off: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (((res_s2.pin_levels ^ {OUT_W{!active_high_q}})
			& ~res_s2.running_mask & OUT_MASK) == '0))
		else $error("stopped LED pin not at off level");

	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("processed item produced no result");

	a_bad_unit: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && req_s1.req_type == REQ_SET
			&& 32'(req_s1.led_unit) >= 32'(NUM_LEDS)) |=> $stable(run_vec))
		else $error("out-of-range unit changed running state");

	a_stopped_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(lit_vec & ~run_vec) == '0)
		else $error("stopped LED still lit");

endmodule
`default_nettype wire

@@ hdl/mlbs_led.sv @@
// Blink state and update logic for one LED.
`default_nettype none
module mlbs_led #(
	parameter int TIME_WIDTH = mlbs_pkg::TIME_WIDTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mlbs_pkg::led_cmd_t  cmd,
	input  wire logic [TIME_WIDTH-1:0] on_time,
	input  wire logic [TIME_WIDTH-1:0] off_time,
	output mlbs_pkg::led_stat_t      cur,
	output mlbs_pkg::led_stat_t      nxt
);
	import mlbs_pkg::*;

	logic                  run_q, run_d;
	logic                  lit_q, lit_d;
	logic                  phase_q, phase_d;
	logic [TIME_WIDTH-1:0] cnt_q, cnt_d, cnt_mid;
	logic [TIME_WIDTH-1:0] on_q, on_d;
	logic [TIME_WIDTH-1:0] off_q, off_d;

	always_comb begin
		run_d   = run_q;
		lit_d   = lit_q;
		phase_d = phase_q;
		cnt_d   = cnt_q;
		cnt_mid = cnt_q;
		on_d    = on_q;
		off_d   = off_q;
		if (cmd.set) begin
			if (on_time != '0 || off_time != '0) begin
				on_d  = on_time;
				off_d = off_time;
				if (!run_q) begin
					run_d   = 1'b1;
					cnt_d   = '0;
					phase_d = 1'b0;
				end
			end else begin
				run_d   = 1'b0;
				on_d    = '0;
				off_d   = '0;
				cnt_d   = '0;
				phase_d = 1'b0;
				lit_d   = 1'b0;
			end
		end else if (cmd.tick && run_q) begin
			if (cnt_q == '0) begin
				phase_d = !phase_q;
				if (phase_q) begin
					if (off_q != '0) begin
						cnt_mid = off_q;
						lit_d   = 1'b0;
					end
				end else if (on_q != '0) begin
					cnt_mid = on_q;
					lit_d   = 1'b1;
				end
			end
			if (cnt_mid != '0) begin
				cnt_d = cnt_mid - 1'b1;
			end else begin
				cnt_d = cnt_mid;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			lit_q   <= 1'b0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			run_q   <= run_d;
			lit_q   <= lit_d;
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		on_q  <= on_d;
		off_q <= off_d;
	end

	assign cur.running = run_q;
	assign cur.lit     = lit_q;
	assign nxt.running = run_d;
	assign nxt.lit     = lit_d;

endmodule
`default_nettype wire
